// File: design/bounded_ordered_list_store_core_assert.svh
// assertion macros used by the checker file
`ifndef BOUNDED_ORDERED_LIST_STORE_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_STORE_CORE_ASSERT_SVH

// consequent must hold in the same cycle
`define BOLS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the following cycle
`define BOLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bols_pkg.sv
package bols_pkg;

  // list geometry
  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // request actions
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT      = 2'd0,
    ACT_REMOVE_REAR = 2'd1,
    ACT_REMOVE_KEY  = 2'd2
  } action_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

// File: design/bols_if.sv
// request channel
interface bols_req_if import bols_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

// result channel
interface bols_rsp_if import bols_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     element_valid;
  logic signed [DATA_W-1:0] element;
  logic [POS_W-1:0]         position;
  logic                     last;

  modport source (output valid, status, element_valid, element, position, last, input ready);
  modport sink (input valid, status, element_valid, element, position, last, output ready);
endinterface

// File: design/bols_ram.sv
module bols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bounded_ordered_list_store_core.sv
// Ordered list store of up to DEPTH signed 32-bit values.
// req channel: action and value; a request is taken only while the block is
// idle (req.ready high). Insert puts the value at the front, remove rear drops
// the entry at the rear, remove key drops the first entry from the front that
// equals value.
// rsp channel: after each request the whole list is sent front to rear, one
// result per entry with position and a last flag; an empty list sends one
// result with element_valid low. status is the same on every result.
// The list sits in a circular buffer in a single RAM with a registered read;
// insert moves the head pointer back, remove key scans from the head and then
// closes the gap by copying the entries behind it down one place.
// Results go out front to rear; each one is read from the RAM and then loaded
// into the output register, and the next request is taken only after the last
// result has been taken. Remove key finishes its scan and its copying before
// the first result is sent.
// A stalled receiver simply holds the current result; nothing is lost.
// Reset empties the list at once (no clearing pass) and drops any result.
module bounded_ordered_list_store_core import bols_pkg::*; (
  input  logic clk,
  input  logic rst,
  bols_req_if.sink   req,
  bols_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_EPRE,
    S_ELOAD,
    S_ESEND
  } state_t;

  localparam ptr_t PTR_LAST = ptr_t'(DEPTH - 1);
  localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

  state_t              state;
  ptr_t                head;
  cnt_t                count;
  ptr_t                rp;
  cnt_t                rl;
  ptr_t                cp;
  cnt_t                cl;
  logic                cv;
  ptr_t                wp;
  logic [DATA_W-1:0]   key;
  status_t             status;

  logic                rsp_valid;
  status_t             o_status;
  logic                o_elem_valid;
  logic [DATA_W-1:0]   o_elem;
  logic [POS_W-1:0]    o_pos;
  logic                o_last;

  logic                we;
  ptr_t                waddr;
  logic [DATA_W-1:0]   wdata;
  logic [DATA_W-1:0]   rdata;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  bols_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rp),
    .rdata(rdata)
  );

  // write port: front insert or gap closing copy
  always_comb begin
    we    = 1'b0;
    waddr = wp;
    wdata = rdata;
    priority if (state == S_IDLE && req.valid && req.action == ACT_INSERT
                 && count != CNT_FULL) begin
      we    = 1'b1;
      waddr = ptr_dec(head);
      wdata = req.value;
    end else if (state == S_SHIFT && cv) begin
      we = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  // handshake and result payload
  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = o_status;
  assign rsp.element_valid = o_elem_valid;
  assign rsp.element       = o_elem;
  assign rsp.position      = o_pos;
  assign rsp.last          = o_last;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      cv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        // take a request and apply the simple actions at once
        S_IDLE: begin
          if (req.valid) begin
            key <= req.value;
            rl  <= '0;
            cv  <= 1'b0;
            unique case (req.action)
              ACT_INSERT: begin
                state <= S_EPRE;
                if (count == CNT_FULL) begin
                  status <= ST_FULL;
                  rp     <= head;
                end else begin
                  status <= ST_DONE;
                  head   <= ptr_dec(head);
                  rp     <= ptr_dec(head);
                  count  <= count + 1'b1;
                end
              end
              ACT_REMOVE_REAR: begin
                rp    <= head;
                state <= S_EPRE;
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  status <= ST_DONE;
                  count  <= count - 1'b1;
                end
              end
              ACT_REMOVE_KEY: begin
                rp <= head;
                if (count == '0) begin
                  status <= ST_EMPTY;
                  state  <= S_EPRE;
                end else begin
                  status <= ST_DONE;
                  state  <= S_SEARCH;
                end
              end
              default: begin
                rp     <= head;
                status <= ST_DONE;
                state  <= S_EPRE;
              end
            endcase
          end
        end

        // scan from the front, one read issued per cycle
        S_SEARCH: begin
          if (cv && rdata == key) begin
            wp    <= cp;
            rp    <= ptr_inc(cp);
            rl    <= cl + 1'b1;
            cv    <= 1'b0;
            state <= S_SHIFT;
          end else if (cv && cl == count - 1'b1) begin
            status <= ST_NOT_FOUND;
            rp     <= head;
            rl     <= '0;
            cv     <= 1'b0;
            state  <= S_EPRE;
          end else if (rl != count) begin
            cp <= rp;
            cl <= rl;
            cv <= 1'b1;
            rp <= ptr_inc(rp);
            rl <= rl + 1'b1;
          end else begin
            cv <= 1'b0;
          end
        end

        // copy the entries behind the match down one place
        S_SHIFT: begin
          if (cv) begin
            wp <= ptr_inc(wp);
          end
          if (rl != count) begin
            cv <= 1'b1;
            rp <= ptr_inc(rp);
            rl <= rl + 1'b1;
          end else begin
            cv <= 1'b0;
            if (!cv) begin
              count <= count - 1'b1;
              rp    <= head;
              rl    <= '0;
              state <= S_EPRE;
            end
          end
        end

        // head read in flight, or the single result of an empty list
        S_EPRE: begin
          if (count == '0) begin
            rsp_valid    <= 1'b1;
            o_status     <= status;
            o_elem_valid <= 1'b0;
            o_elem       <= '0;
            o_pos        <= '0;
            o_last       <= 1'b1;
            state        <= S_ESEND;
          end else begin
            state <= S_ELOAD;
          end
        end

        // load the next entry into the output register
        S_ELOAD: begin
          rsp_valid    <= 1'b1;
          o_status     <= status;
          o_elem_valid <= 1'b1;
          o_elem       <= rdata;
          o_pos        <= POS_W'(rl);
          o_last       <= (rl == count - 1'b1);
          rp           <= ptr_inc(rp);
          rl           <= rl + 1'b1;
          state        <= S_ESEND;
        end

        // hold the result until it is taken
        S_ESEND: begin
          if (rsp.ready) begin
            rsp_valid <= 1'b0;
            state     <= o_last ? S_IDLE : S_ELOAD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/bols_checker.sv
`include "bounded_ordered_list_store_core_assert.svh"

module bols_checker import bols_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic [STAT_W-1:0]        rsp_status,
  input logic                     rsp_element_valid,
  input logic signed [DATA_W-1:0] rsp_element,
  input logic [POS_W-1:0]         rsp_position,
  input logic                     rsp_last
);

  // an empty list result is a lone, zeroed, final result
  `BOLS_ASSERT_NOW(a_empty_shape, clk, rst, rsp_valid && !rsp_element_valid, rsp_last && rsp_position == '0 && rsp_element == '0, "empty list result malformed")

  // no new request is taken while results are still going out
  `BOLS_ASSERT_NOW(a_no_overlap, clk, rst, rsp_valid, !req_ready, "request taken during output")

  // a full or key miss outcome implies a non-empty list
  `BOLS_ASSERT_NOW(a_status_list, clk, rst, rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND), rsp_element_valid, "status without list entries")

  // after the final result the block is idle again
  `BOLS_ASSERT_NEXT(a_back_idle, clk, rst, rsp_valid && rsp_ready && rsp_last, req_ready && !rsp_valid, "not idle after last result")

  // stalled result holds
  `BOLS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_element) && $stable(rsp_last) && $stable(rsp_position), "stalled result changed")

endmodule

bind bounded_ordered_list_store_core bols_checker u_bols_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_element_valid(rsp.element_valid),
  .rsp_element      (rsp.element),
  .rsp_position     (rsp.position),
  .rsp_last         (rsp.last)
);
